// ----- rtl/ecs_pkg.sv -----
// ============================================================================
// ecs_pkg: shared types and constants
// Widths, operation codes and register indexes for the epidemic step core.
// ============================================================================
package ecs_pkg;

    localparam int FracBits  = 16;
    localparam int CntW      = 32 + FracBits;
    localparam int RateW     = FracBits + 1;
    localparam int BetaW     = FracBits + 4;
    localparam int CfgDataW  = CntW;
    localparam int CfgIdxW   = 3;
    localparam int DivW      = 128;
    localparam int DivCntW   = $clog2(DivW);

    localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};
    localparam logic [RateW-1:0] OneQ  = RateW'(1) << FracBits;

    localparam logic OpStart = 1'b0;
    localparam logic OpDay   = 1'b1;

    localparam logic [CfgIdxW-1:0] RegPopulation  = 3'd0;
    localparam logic [CfgIdxW-1:0] RegInfRate     = 3'd1;
    localparam logic [CfgIdxW-1:0] RegRecRate     = 3'd2;
    localparam logic [CfgIdxW-1:0] RegDeathRate   = 3'd3;
    localparam logic [CfgIdxW-1:0] RegVacPerDay   = 3'd4;
    localparam logic [CfgIdxW-1:0] RegVacEff      = 3'd5;
    localparam logic [CfgIdxW-1:0] RegLockDay     = 3'd6;
    localparam logic [CfgIdxW-1:0] RegLockRed     = 3'd7;

    // Handshake between the sequencer and the shared divider.
    typedef struct packed {
        logic             start;
        logic [DivW-1:0]  num;
        logic [DivW-1:0]  den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DivW-1:0]  quo;
    } div_rsp_t;

    function automatic logic [CntW-1:0] sat_add(input logic [CntW-1:0] a,
                                                input logic [CntW-1:0] b);
        logic [CntW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CntW] ? CntMax : s[CntW-1:0];
    endfunction

endpackage

// ----- rtl/ecs_mul.sv -----
// ============================================================================
// ecs_mul: shared 32x32 multiplier
// One registered 32 by 32 product; wide products are built from partials.
// ============================================================================
module ecs_mul
    import ecs_pkg::*;
(
    input  logic        aclk,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [63:0] prod
);

    logic [63:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= 64'(op_a) * 64'(op_b);
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/ecs_div.sv -----
// ============================================================================
// ecs_div: restoring divider
// Bit-serial 128 by 128 division, one quotient bit per cycle.
// ============================================================================
module ecs_div
    import ecs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg;
    logic [DivCntW-1:0] cnt_reg;
    logic [DivW-1:0]   num_reg, den_reg, quo_reg, rem_reg;
    logic              done_reg;
    logic [DivW:0]     rem_sh;
    logic [DivW:0]     diff;

    assign rem_sh = {rem_reg, num_reg[DivW-1]};
    assign diff   = rem_sh - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DivCntW'(DivW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= num_reg << 1;
            if (!diff[DivW]) begin
                rem_reg <= diff[DivW-1:0];
                quo_reg <= {quo_reg[DivW-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[DivW-1:0];
                quo_reg <= {quo_reg[DivW-2:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        !(req.start && busy_reg))
        else $error("divider started while busy");
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("done held for more than one cycle");
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("done raised while still busy");

endmodule

// ----- rtl/epidemic_compartment_step_core.sv -----
// ============================================================================
// epidemic_compartment_step_core: SIRD-V discrete day step
// Sequencer around one shared multiplier and one serial divider.
// ============================================================================
// Usage: configure the eight registers through cfg_we/cfg_index/cfg_data
// while no word is in flight. Send a word on s_* with s_operation start to
// load the compartments, then one word per day. Each input word yields one
// result word on m_* holding all compartments and the peak.
// A start word goes from idle straight to the output state. A day word runs
// 32x32 partial products for beta*S*I, the infection division on the
// bit-serial divider, product steps for the recovery, death and vaccination
// flows, then states that total the flows, update, track the peak and register
// the result. The lockdown day adds the beta cut first, and a day whose flows
// exceed susceptible adds the two scaling divisions, each after its product.
// One word is worked on at a time; s_ready is low from acceptance until the
// result has been registered, and high again in the cycle after.
// The result sits in the output register until m_ready. The next word may be
// accepted and computed meanwhile, but its result waits, with s_ready low,
// until the previous one has been taken.
// Reset (aresetn low, synchronous) clears the compartments, peak, beta and
// the registers to their defaults (population one, lockdown day minus one).
// ============================================================================
module epidemic_compartment_step_core
    import ecs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_operation,
    input  logic [15:0]         s_day,
    input  logic [31:0]         s_initial_infected,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [CntW-1:0]     m_susceptible,
    output logic [CntW-1:0]     m_infected,
    output logic [CntW-1:0]     m_recovered,
    output logic [CntW-1:0]     m_dead,
    output logic [CntW-1:0]     m_vaccinated,
    output logic [CntW-1:0]     m_peak_infected,
    output logic [15:0]         m_peak_day
);

    // Sequencer states.
    typedef enum logic [15:0] {
        ST_IDLE  = 16'h0001,
        ST_LOCK  = 16'h0002,
        ST_MUL   = 16'h0004,
        ST_DIVI  = 16'h0008,
        ST_WDIVI = 16'h0010,
        ST_FLOW  = 16'h0020,
        ST_VAC   = 16'h0040,
        ST_TOT   = 16'h0080,
        ST_SDIV1 = 16'h0100,
        ST_WDIV1 = 16'h0200,
        ST_SDIV2 = 16'h0400,
        ST_WDIV2 = 16'h0800,
        ST_UPD   = 16'h1000,
        ST_PEAK  = 16'h2000,
        ST_OUT   = 16'h4000
    } state_t;

    // Configuration registers.
    logic [31:0]      pop_reg;
    logic [BetaW-1:0] beta0_reg;
    logic [RateW-1:0] gamma_reg, mu_reg, eff_reg, lred_reg;
    logic [CntW-1:0]  vpd_reg;
    logic [16:0]      lday_reg;

    // Model state.
    logic [CntW-1:0]  s_reg, i_reg, r_reg, d_reg, v_reg, pk_reg;
    logic [BetaW-1:0] beta_reg;
    logic [15:0]      pkday_reg, day_reg;

    // Working registers. The raw vaccination flow can reach twice the
    // susceptible count when effectiveness is above one, so it keeps one
    // extra bit until the scaling has bounded it.
    state_t           st_reg;
    logic [4:0]       step_reg;
    logic [127:0]     acc_reg;      // partial product accumulator
    logic [CntW-1:0]  ni_reg, nr_reg, nd_reg;
    logic [CntW:0]    vac_reg;
    logic [CntW+1:0]  tot_reg;
    logic [127:0]     sxi_reg;

    // Output register.
    logic             mv_reg;
    logic [CntW-1:0]  o_s_reg, o_i_reg, o_r_reg, o_d_reg, o_v_reg, o_pk_reg;
    logic [15:0]      o_pkd_reg;

    // Shared units.
    logic [31:0]  mul_a, mul_b;
    logic [63:0]  mul_p;
    div_req_t     dreq;
    div_rsp_t     drsp;

    ecs_mul u_mul (.aclk(aclk), .op_a(mul_a), .op_b(mul_b), .prod(mul_p));
    ecs_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    // Multiplication program: step selects which 32-bit limbs enter the
    // multiplier; the registered product returns in the next cycle. Products are
    // an operand A times an operand B, each of up to 64 bits, done as 2x2
    // limbs (4 products, accumulate into acc_reg at limb offsets).
    logic [63:0] opa_w, opb_w;

    // Multiply job operands chosen by state/step group.
    // Group coding within ST_MUL / ST_FLOW / ST_VAC / ST_SDIV*.
    always_comb begin
        opa_w = '0;
        opb_w = '0;
        unique case (st_reg)
            ST_LOCK: begin
                opa_w = 64'(beta0_reg);
                opb_w = 64'((lred_reg >= OneQ) ? RateW'(0) : OneQ - lred_reg);
            end
            ST_MUL: begin
                if (step_reg < 5'd5) begin
                    opa_w = 64'(s_reg);
                    opb_w = 64'(i_reg);
                end else begin
                    // beta times the 96-bit S*I: two 64-bit halves in turn
                    opa_w = (step_reg < 5'd10) ? sxi_reg[63:0] : sxi_reg[127:64];
                    opb_w = 64'(beta_reg);
                end
            end
            ST_FLOW: begin
                opa_w = 64'(i_reg);
                opb_w = (step_reg < 5'd5) ? 64'(gamma_reg) : 64'(mu_reg);
            end
            ST_VAC: begin
                opa_w = 64'((vpd_reg < s_reg - ni_reg) ? vpd_reg : s_reg - ni_reg);
                opb_w = 64'(eff_reg);
            end
            ST_SDIV1: begin
                opa_w = 64'(ni_reg);
                opb_w = 64'(s_reg);
            end
            ST_SDIV2: begin
                opa_w = 64'(vac_reg);
                opb_w = 64'(s_reg);
            end
            default: begin
                opa_w = '0;
                opb_w = '0;
            end
        endcase
    end

    // Limb index within a 5-step group: steps k=0..3 issue, k=1..4 collect.
    logic [2:0] k_in;
    always_comb begin
        priority if (step_reg >= 5'd10) begin
            k_in = 3'(step_reg - 5'd10);
        end else if (step_reg >= 5'd5) begin
            k_in = 3'(step_reg - 5'd5);
        end else begin
            k_in = 3'(step_reg);
        end
    end

    assign mul_a = k_in[1] ? opa_w[63:32] : opa_w[31:0];
    assign mul_b = k_in[0] ? opb_w[63:32] : opb_w[31:0];

    // Collected product: issued at k-1.
    logic [2:0]   k_prev;
    logic [127:0] part_sh;
    assign k_prev  = k_in - 3'd1;
    assign part_sh = 128'(mul_p) << (7'(k_prev[1]) * 7'd32 + 7'(k_prev[0]) * 7'd32);

    logic [CntW-1:0] new_i_floor, sub_s;
    logic [CntW-1:0] i_base, i_new;
    logic [CntW+1:0] tot_w;

    assign tot_w    = {2'b00, ni_reg} + {1'b0, vac_reg};
    assign sub_s    = s_reg - (ni_reg + vac_reg[CntW-1:0]);
    assign i_base   = i_reg - nr_reg - nd_reg;
    assign i_new    = sat_add(i_base, ni_reg);
    assign new_i_floor = (|drsp.quo[127:CntW] || drsp.quo[CntW-1:0] > s_reg)
                       ? s_reg : drsp.quo[CntW-1:0];

    logic [31:0] pop_eff;
    assign pop_eff = (pop_reg == '0) ? 32'd1 : pop_reg;

    logic s_fire, m_fire;
    assign s_fire = s_valid && s_ready;
    assign m_fire = m_valid && m_ready;
    assign s_ready = (st_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pop_reg   <= 32'd1;
            beta0_reg <= '0;
            gamma_reg <= '0;
            mu_reg    <= '0;
            vpd_reg   <= '0;
            eff_reg   <= '0;
            lday_reg  <= 17'h1FFFF;
            lred_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                RegPopulation: pop_reg   <= cfg_data[31:0];
                RegInfRate:    beta0_reg <= cfg_data[BetaW-1:0];
                RegRecRate:    gamma_reg <= cfg_data[RateW-1:0];
                RegDeathRate:  mu_reg    <= cfg_data[RateW-1:0];
                RegVacPerDay:  vpd_reg   <= cfg_data[CntW-1:0];
                RegVacEff:     eff_reg   <= cfg_data[RateW-1:0];
                RegLockDay:    lday_reg  <= cfg_data[16:0];
                RegLockRed:    lred_reg  <= cfg_data[RateW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_IDLE;
            step_reg  <= '0;
            mv_reg    <= 1'b0;
            s_reg     <= '0;
            i_reg     <= '0;
            r_reg     <= '0;
            d_reg     <= '0;
            v_reg     <= '0;
            pk_reg    <= '0;
            pkday_reg <= '0;
            beta_reg  <= '0;
            dreq.start <= 1'b0;
        end else begin
            dreq.start <= 1'b0;
            if (m_fire) mv_reg <= 1'b0;
            unique case (st_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        day_reg <= s_day;
                        if (s_operation == OpStart) begin
                            s_reg <= (pop_reg > s_initial_infected)
                                   ? CntW'(pop_reg - s_initial_infected) << FracBits
                                   : '0;
                            i_reg    <= CntW'(s_initial_infected) << FracBits;
                            pk_reg   <= CntW'(s_initial_infected) << FracBits;
                            r_reg    <= '0;
                            d_reg    <= '0;
                            v_reg    <= '0;
                            pkday_reg <= '0;
                            beta_reg <= beta0_reg;
                            st_reg   <= ST_OUT;
                        end else begin
                            step_reg <= '0;
                            acc_reg  <= '0;
                            st_reg   <= ({1'b0, s_day} == lday_reg) ? ST_LOCK : ST_MUL;
                        end
                    end
                end
                ST_LOCK: begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg != '0) acc_reg <= acc_reg + part_sh;
                    if (step_reg == 5'd4) begin
                        beta_reg <= BetaW'((acc_reg + part_sh) >> FracBits);
                        step_reg <= '0;
                        acc_reg  <= '0;
                        st_reg   <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    step_reg <= step_reg + 1'b1;
                    if (k_in != 3'd0) acc_reg <= acc_reg + part_sh;
                    if (step_reg == 5'd4) begin
                        sxi_reg <= acc_reg + part_sh;
                        acc_reg <= '0;
                    end else if (step_reg == 5'd9) begin
                        sxi_reg[63:0] <= 64'((acc_reg + part_sh) >> 0);
                        ni_reg <= CntW'(((acc_reg + part_sh) >> 64));
                        // low half product kept in nr_reg and nd_reg below
                        tot_reg <= '0;
                        acc_reg <= '0;
                        // save low half product as 96 bits via nd/nr regs
                        nr_reg  <= CntW'(acc_reg + part_sh);
                        nd_reg  <= CntW'((acc_reg + part_sh) >> CntW);
                    end else if (step_reg == 5'd14) begin
                        // num = low + (high << 64)
                        dreq.num <= {32'(nd_reg >> 16), nd_reg[15:0], nr_reg}
                                  + ((acc_reg + part_sh) << 64);
                        dreq.den <= 128'(pop_eff) << (2 * FracBits);
                        dreq.start <= 1'b1;
                        step_reg <= '0;
                        acc_reg  <= '0;
                        st_reg   <= ST_WDIVI;
                    end
                end
                ST_WDIVI: begin
                    if (drsp.done) begin
                        ni_reg   <= new_i_floor;
                        step_reg <= '0;
                        acc_reg  <= '0;
                        st_reg   <= ST_FLOW;
                    end
                end
                ST_FLOW: begin
                    step_reg <= step_reg + 1'b1;
                    if (k_in != 3'd0) acc_reg <= acc_reg + part_sh;
                    if (step_reg == 5'd4) begin
                        nr_reg  <= ((((acc_reg + part_sh) >> FracBits) > 128'(i_reg)))
                                 ? i_reg : CntW'((acc_reg + part_sh) >> FracBits);
                        acc_reg <= '0;
                    end else if (step_reg == 5'd9) begin
                        nd_reg <= ((((acc_reg + part_sh) >> FracBits) > 128'(i_reg - nr_reg)))
                                ? i_reg - nr_reg : CntW'((acc_reg + part_sh) >> FracBits);
                        acc_reg  <= '0;
                        step_reg <= '0;
                        st_reg   <= ST_VAC;
                    end
                end
                ST_VAC: begin
                    step_reg <= step_reg + 1'b1;
                    if (k_in != 3'd0) acc_reg <= acc_reg + part_sh;
                    if (step_reg == 5'd4) begin
                        vac_reg  <= (CntW+1)'((acc_reg + part_sh) >> FracBits);
                        acc_reg  <= '0;
                        step_reg <= '0;
                        st_reg   <= ST_TOT;
                    end
                end
                ST_TOT: begin
                    tot_reg <= tot_w;
                    st_reg  <= (tot_w > {2'b00, s_reg}) ? ST_SDIV1 : ST_UPD;
                end
                ST_SDIV1, ST_SDIV2: begin
                    step_reg <= step_reg + 1'b1;
                    if (k_in != 3'd0) acc_reg <= acc_reg + part_sh;
                    if (step_reg == 5'd4) begin
                        dreq.num   <= acc_reg + part_sh;
                        dreq.den   <= 128'(tot_reg);
                        dreq.start <= 1'b1;
                        acc_reg    <= '0;
                        step_reg   <= '0;
                        st_reg     <= (st_reg == ST_SDIV1) ? ST_WDIV1 : ST_WDIV2;
                    end
                end
                ST_WDIV1: begin
                    if (drsp.done) begin
                        ni_reg <= drsp.quo[CntW-1:0];
                        st_reg <= ST_SDIV2;
                    end
                end
                ST_WDIV2: begin
                    if (drsp.done) begin
                        vac_reg <= drsp.quo[CntW:0];
                        st_reg  <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    s_reg  <= sub_s;
                    v_reg  <= sat_add(v_reg, vac_reg[CntW-1:0]);
                    i_reg  <= i_new;
                    r_reg  <= sat_add(r_reg, nr_reg);
                    d_reg  <= sat_add(d_reg, nd_reg);
                    st_reg <= ST_PEAK;
                end
                ST_PEAK: begin
                    if (i_reg > pk_reg) begin
                        pk_reg    <= i_reg;
                        pkday_reg <= day_reg;
                    end
                    st_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!mv_reg || m_fire) begin
                        mv_reg    <= 1'b1;
                        o_s_reg   <= s_reg;
                        o_i_reg   <= i_reg;
                        o_r_reg   <= r_reg;
                        o_d_reg   <= d_reg;
                        o_v_reg   <= v_reg;
                        o_pk_reg  <= (i_reg > pk_reg) ? i_reg : pk_reg;
                        o_pkd_reg <= pkday_reg;
                        st_reg    <= ST_IDLE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid         = mv_reg;
    assign m_susceptible   = o_s_reg;
    assign m_infected      = o_i_reg;
    assign m_recovered     = o_r_reg;
    assign m_dead          = o_d_reg;
    assign m_vaccinated    = o_v_reg;
    assign m_peak_infected = o_pk_reg;
    assign m_peak_day      = o_pkd_reg;

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> st_reg == ST_IDLE)
        else $error("ready outside idle");
    a_peak_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_PEAK) |=> pk_reg >= $past(pk_reg))
        else $error("peak decreased in a day");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_infected))
        else $error("result overwritten while stalled");
    a_s_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_UPD) |-> (ni_reg + vac_reg) <= s_reg)
        else $error("flows exceed susceptible");

endmodule
